@@ src/brf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

   // search phase as seen between items
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_EVAL_A    = 4'd1,
      PH_EVAL_B    = 4'd2,
      PH_BISECT0   = 4'd3,
      PH_WIDEN_A   = 4'd4,
      PH_WIDEN_B   = 4'd5,
      PH_WIDEN_ONE = 4'd6,
      PH_BISECT_W  = 4'd7,
      PH_BRENT     = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_HALF,
      OP_AVG,
      OP_MUL,
      OP_MULE,
      OP_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef enum logic [2:0] {
      AS_IDLE,
      AS_MUL,
      AS_MFIN,
      AS_DIV,
      AS_DFIN
   } alu_state_type;

   typedef enum logic [5:0] {
      S_IDLE, S_EMIT, S_BIS_AVG, S_WID_A, S_WID_B, S_NEXT_BR,
      S_B0, S_B0S, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8, S_B9,
      S_S1, S_S2, S_S3,
      S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8,
      S_I9, S_I10, S_I11, S_I12, S_I13, S_I14, S_I15, S_I16,
      S_SIGN,
      S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10, S_C11,
      S_STEP
   } seq_state_type;

   localparam logic OPN_START  = 1'b0;
   localparam logic OPN_ANSWER = 1'b1;

   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_ROOT    = 2'd1;
   localparam logic [1:0] KIND_FAIL    = 2'd2;

   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_BOTH_UNDEF    = 3'd1;
   localparam logic [2:0] ERR_NO_DEFINED    = 3'd2;
   localparam logic [2:0] ERR_NOT_BRACKETED = 3'd3;
   localparam logic [2:0] ERR_UNDEF_ITER    = 3'd4;
   localparam logic [2:0] ERR_TOO_MANY      = 3'd5;

   localparam logic [2:0] CSR_WIDEN_STEP = 3'd0;
   localparam logic [2:0] CSR_ABS_TOL    = 3'd1;
   localparam logic [2:0] CSR_REL_EPS    = 3'd2;
   localparam logic [2:0] CSR_MAX_TRIES  = 3'd3;
   localparam logic [2:0] CSR_MAX_ITER   = 3'd4;

   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_LOWER = 2'd1;
   localparam logic [1:0] SIDE_UPPER = 2'd2;

   localparam logic [62:0] RST_WIDEN_STEP = 63'd10995116277760;
   localparam logic [62:0] RST_ABS_TOL    = 63'd109951;
   localparam logic [39:0] RST_REL_EPS    = 40'd32985;
   localparam logic [3:0]  RST_MAX_TRIES  = 4'd5;
   localparam logic [9:0]  RST_MAX_ITER   = 10'd1000;

   localparam int EPS_FRAC   = 40;
   localparam int DIGIT_BITS = 16;

endpackage
`default_nettype wire

@@ src/brf_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
module brf_alu #(
   parameter int WORD_BITS = 64,
   parameter int FRAC_BITS = 40
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire brf_pkg::alu_ctl_type        ctl,
   input  wire logic signed [WORD_BITS-1:0] x_op,
   input  wire logic signed [WORD_BITS-1:0] y_op,
   output logic                             done,
   output logic signed [WORD_BITS-1:0]      res
);
   import brf_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int NB = W + FRAC_BITS;
   localparam int ND = (W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int MW = ND * DIGIT_BITS;
   localparam int CW = $clog2(NB + 1);
   localparam int PW = 2 * W + 1;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   alu_state_type        st_ff, st_in;
   alu_op_type           op_ff, op_in;
   logic                 neg_ff, neg_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [2*W-1:0]       acc_ff, acc_in;
   logic [W-1:0]         mcand_ff, mcand_in;
   logic [MW-1:0]        mplier_ff, mplier_in;
   logic [NB-1:0]        num_ff, num_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [NB-1:0]        quo_ff, quo_in;
   logic [W-1:0]         den_ff, den_in;
   logic                 done_ff, done_in;
   logic signed [W-1:0]  res_ff, res_in;

   logic [W-1:0]         mag_x, mag_y;
   logic [W:0]           sum_w, dif_w;
   logic [W+DIGIT_BITS-1:0] pprod;
   logic [W:0]           rem_try;
   logic [PW-1:0]        rnd_m, rnd_e, shf, lim_p, mag_p;
   logic [NB-1:0]        lim_q, mag_q;

   assign mag_x = x_op[W-1] ? (~x_op + 1'b1) : x_op;
   assign mag_y = y_op[W-1] ? (~y_op + 1'b1) : y_op;
   assign sum_w = {x_op[W-1], x_op} + {y_op[W-1], y_op};
   assign dif_w = {x_op[W-1], x_op} - {y_op[W-1], y_op};

   assign pprod   = mcand_ff * mplier_ff[MW-1 -: DIGIT_BITS];
   assign rem_try = {rem_ff, num_ff[NB-1]};

   // round half away from zero on the magnitude, then saturate
   assign rnd_m = {1'b0, acc_ff} + (PW'(1) << (FRAC_BITS - 1));
   assign rnd_e = {1'b0, acc_ff} + (PW'(1) << (EPS_FRAC - 1));
   assign shf   = (op_ff == OP_MULE) ? (rnd_e >> EPS_FRAC) : (rnd_m >> FRAC_BITS);
   assign lim_p = neg_ff ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
   assign mag_p = (shf > lim_p) ? lim_p : shf;
   assign lim_q = neg_ff ? (NB'(1) << (W - 1)) : ((NB'(1) << (W - 1)) - NB'(1));
   assign mag_q = (quo_ff > lim_q) ? lim_q : quo_ff;

   always_comb begin
      st_in     = st_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      case (st_ff)
         AS_IDLE: begin
            if (ctl.start) begin
               op_in  = ctl.op;
               neg_in = x_op[W-1] ^ y_op[W-1];
               case (ctl.op)
                  OP_ADD: begin
                     res_in  = (sum_w[W] != sum_w[W-1]) ? (sum_w[W] ? WMIN : WMAX)
                                                         : sum_w[W-1:0];
                     done_in = 1'b1;
                  end
                  OP_SUB: begin
                     res_in  = (dif_w[W] != dif_w[W-1]) ? (dif_w[W] ? WMIN : WMAX)
                                                         : dif_w[W-1:0];
                     done_in = 1'b1;
                  end
                  OP_HALF: begin
                     res_in  = x_op >>> 1;
                     done_in = 1'b1;
                  end
                  OP_AVG: begin
                     res_in  = sum_w[W:1];
                     done_in = 1'b1;
                  end
                  OP_MUL, OP_MULE: begin
                     mcand_in  = mag_x;
                     mplier_in = MW'(mag_y);
                     acc_in    = '0;
                     cnt_in    = CW'(ND);
                     st_in     = AS_MUL;
                  end
                  OP_DIV: begin
                     if (mag_y == '0) begin
                        res_in  = (mag_x == '0) ? '0
                                                : ((x_op[W-1] ^ y_op[W-1]) ? WMIN : WMAX);
                        done_in = 1'b1;
                     end else begin
                        num_in = NB'(mag_x) << FRAC_BITS;
                        den_in = mag_y;
                        rem_in = '0;
                        quo_in = '0;
                        cnt_in = CW'(NB);
                        st_in  = AS_DIV;
                     end
                  end
                  default: begin
                     res_in  = '0;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         AS_MUL: begin
            // one 16-bit digit of the multiplier a cycle, top digit first
            acc_in    = (acc_ff << DIGIT_BITS) + (2*W)'(pprod);
            mplier_in = mplier_ff << DIGIT_BITS;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) st_in = AS_MFIN;
         end
         AS_MFIN: begin
            res_in  = neg_ff ? -mag_p[W-1:0] : mag_p[W-1:0];
            done_in = 1'b1;
            st_in   = AS_IDLE;
         end
         AS_DIV: begin
            // restoring division, one quotient bit a cycle
            if (rem_try >= {1'b0, den_ff}) begin
               rem_in = W'(rem_try - {1'b0, den_ff});
               quo_in = {quo_ff[NB-2:0], 1'b1};
            end else begin
               rem_in = rem_try[W-1:0];
               quo_in = {quo_ff[NB-2:0], 1'b0};
            end
            num_in = num_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) st_in = AS_DFIN;
         end
         AS_DFIN: begin
            res_in  = neg_ff ? -mag_q[W-1:0] : mag_q[W-1:0];
            done_in = 1'b1;
            st_in   = AS_IDLE;
         end
         default: st_in = AS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= AS_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      res_ff    <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule
`default_nettype wire

@@ src/bracketed_root_finder_top.sv @@
// Bracketed root finder, Brent's method, driven as a request and answer loop.
// Input channel (req_*): an item with operation start carries two bounds; an
// item with operation answer carries the function value at the last point
// asked for, or flags it undefined. Result channel (rsp_*): each item either
// asks for the function at a point, reports the root, or a numbered failure.
// Every accepted item gives exactly one result, except an answer while no
// search runs, which is dropped. req_stall is high from acceptance until the
// result has been loaded into the output register.
// A Brent iteration runs its steps on one shared arithmetic unit, and the worst
// iteration holds four divides. One item is in work at a time. A stalled result
// holds the output register; the sequencer waits for it before it loads the next
// one. Reset loads the register defaults, clears the search state and leaves no
// result pending. Configuration writes on csr_* take effect at once; the user is
// to make them only while no item is in work, and the block itself does not
// enforce this.
`timescale 1ns / 1ps
`default_nettype none
module bracketed_root_finder_top #(
   parameter int WORD_BITS = 64,
   parameter int FRAC_BITS = 40
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire logic signed [63:0] req_lower_bound,
   input  wire logic signed [63:0] req_upper_bound,
   input  wire logic signed [63:0] req_function_value,
   input  wire logic               req_value_undefined,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_result_kind,
   output logic signed [63:0]      rsp_point,
   output logic [2:0]              rsp_error_code,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [62:0]        csr_data
);
   import brf_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [63:0] WMAX64 = 64'(WMAX);
   localparam logic signed [63:0] WMIN64 = 64'(WMIN);
   localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
   localparam logic signed [W-1:0] ONE_Q = (ONE64 > 64'(WMAX64)) ? WMAX : ONE64[W-1:0];

   function automatic logic signed [W-1:0] abs_q(input logic signed [W-1:0] x);
      abs_q = (x == WMIN) ? WMAX : ((x < 0) ? -x : x);
   endfunction

   function automatic logic signed [W-1:0] neg_q(input logic signed [W-1:0] x);
      neg_q = (x == WMIN) ? WMAX : -x;
   endfunction

   function automatic logic signed [W-1:0] clamp_in(input logic signed [63:0] x);
      if (x > WMAX64) clamp_in = WMAX;
      else if (x < WMIN64) clamp_in = WMIN;
      else clamp_in = x[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] cfg_q(input logic [63:0] x);
      cfg_q = (x > 64'(WMAX64)) ? WMAX : x[W-1:0];
   endfunction

   // configuration
   logic [62:0] widen_ff, atol_ff;
   logic [39:0] eps_ff;
   logic [3:0]  maxtry_ff;
   logic [9:0]  maxit_ff;

   // search state
   seq_state_type st_ff, st_in;
   phase_type     phase_ff, phase_in;
   logic          wait_ff, wait_in;
   logic [1:0]    side_ff, side_in;
   logic [9:0]    iter_ff, iter_in;
   logic [3:0]    tries_ff, tries_in;
   logic signed [W-1:0] b_ff, b_in, a_ff, a_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   logic signed [W-1:0] fb_ff, fb_in, fa_ff, fa_in, fc_ff, fc_in;
   logic signed [W-1:0] bad_ff, bad_in, good_ff, good_in;
   logic signed [W-1:0] tol_ff, tol_in, m_ff, m_in, s_ff, s_in, p_ff, p_in;
   logic signed [W-1:0] q_ff, q_in, r_ff, r_in, t1_ff, t1_in, t2_ff, t2_in;

   // pending and presented result
   logic [1:0]          pend_kind_ff, pend_kind_in;
   logic signed [W-1:0] pend_pt_ff, pend_pt_in;
   logic [2:0]          pend_err_ff, pend_err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic signed [63:0]  rsp_point_ff, rsp_point_in;
   logic [2:0]          rsp_err_ff, rsp_err_in;

   logic signed [W-1:0] st_q, atol_q, eps_q, v_cl, step_c;
   logic                accept, use_alu, alu_done, first_bis;
   alu_ctl_type         alu_ctl;
   alu_op_type          alu_op_c;
   logic signed [W-1:0] alu_x_c, alu_y_c, alu_res;

   assign st_q   = cfg_q({1'b0, widen_ff});
   assign atol_q = cfg_q({1'b0, atol_ff});
   assign eps_q  = cfg_q({24'd0, eps_ff});
   assign v_cl   = clamp_in(req_function_value);

   assign req_stall = (st_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign first_bis = (phase_ff == PH_BISECT0);
   assign step_c    = (abs_q(d_ff) > tol_ff) ? d_ff : ((m_ff > 0) ? tol_ff : neg_q(tol_ff));

   assign alu_ctl.start = use_alu && !wait_ff;
   assign alu_ctl.op    = alu_op_c;

   brf_alu #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_alu (
      .clock(clock),
      .reset(reset),
      .ctl  (alu_ctl),
      .x_op (alu_x_c),
      .y_op (alu_y_c),
      .done (alu_done),
      .res  (alu_res)
   );

   always_comb begin
      st_in = st_ff;  phase_in = phase_ff;  side_in = side_ff;
      iter_in = iter_ff;  tries_in = tries_ff;
      b_in = b_ff;  a_in = a_ff;  c_in = c_ff;  d_in = d_ff;  e_in = e_ff;
      fb_in = fb_ff;  fa_in = fa_ff;  fc_in = fc_ff;  bad_in = bad_ff;  good_in = good_ff;
      tol_in = tol_ff;  m_in = m_ff;  s_in = s_ff;  p_in = p_ff;  q_in = q_ff;  r_in = r_ff;
      t1_in = t1_ff;  t2_in = t2_ff;
      pend_kind_in = pend_kind_ff;  pend_pt_in = pend_pt_ff;  pend_err_in = pend_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;  rsp_point_in = rsp_point_ff;  rsp_err_in = rsp_err_ff;
      use_alu = 1'b0;  alu_op_c = OP_ADD;  alu_x_c = '0;  alu_y_c = '0;

      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OPN_START) begin
                  a_in = clamp_in(req_lower_bound);
                  b_in = clamp_in(req_upper_bound);
                  side_in = SIDE_NONE;  iter_in = '0;  tries_in = '0;
                  pend_kind_in = KIND_REQUEST;  pend_pt_in = clamp_in(req_lower_bound);
                  pend_err_in = ERR_NONE;  phase_in = PH_EVAL_A;  st_in = S_EMIT;
               end else begin
                  pend_kind_in = KIND_FAIL;  pend_pt_in = '0;  pend_err_in = ERR_NO_DEFINED;
                  case (phase_ff)
                     PH_EVAL_A: begin
                        fa_in = v_cl;
                        side_in = req_value_undefined ? SIDE_LOWER : SIDE_NONE;
                        pend_kind_in = KIND_REQUEST;  pend_pt_in = b_ff;  pend_err_in = ERR_NONE;
                        phase_in = PH_EVAL_B;  st_in = S_EMIT;
                     end
                     PH_EVAL_B: begin
                        if (side_ff == SIDE_LOWER && req_value_undefined) begin
                           pend_err_in = ERR_BOTH_UNDEF;  phase_in = PH_IDLE;  st_in = S_EMIT;
                        end else if (side_ff != SIDE_LOWER && !req_value_undefined) begin
                           fb_in = v_cl;  side_in = SIDE_NONE;  tries_in = '0;
                           st_in = S_NEXT_BR;
                        end else begin
                           if (side_ff == SIDE_LOWER) begin
                              fb_in = v_cl;  bad_in = a_ff;  good_in = b_ff;
                           end else begin
                              side_in = SIDE_UPPER;  good_in = a_ff;  bad_in = b_ff;
                           end
                           iter_in = '0;  phase_in = PH_BISECT0;  st_in = S_BIS_AVG;
                        end
                     end
                     PH_BISECT0, PH_BISECT_W: begin
                        if (req_value_undefined) begin
                           if (iter_ff >= maxit_ff) begin
                              phase_in = PH_IDLE;  st_in = S_EMIT;
                           end else begin
                              bad_in = c_ff;  iter_in = iter_ff + 1'b1;  st_in = S_BIS_AVG;
                           end
                        end else begin
                           fc_in = v_cl;
                           if (side_ff == SIDE_LOWER) begin
                              a_in = c_ff;  fa_in = v_cl;
                           end else begin
                              b_in = c_ff;  fb_in = v_cl;
                           end
                           tries_in = first_bis ? 4'd0 : tries_ff + 1'b1;
                           st_in = S_NEXT_BR;
                        end
                     end
                     PH_WIDEN_A: begin
                        if (req_value_undefined) begin
                           phase_in = PH_IDLE;  st_in = S_EMIT;
                        end else begin
                           fa_in = v_cl;  phase_in = PH_WIDEN_B;  st_in = S_WID_B;
                        end
                     end
                     PH_WIDEN_B: begin
                        if (req_value_undefined) begin
                           phase_in = PH_IDLE;  st_in = S_EMIT;
                        end else begin
                           fb_in = v_cl;  tries_in = tries_ff + 1'b1;  st_in = S_NEXT_BR;
                        end
                     end
                     PH_WIDEN_ONE: begin
                        if (req_value_undefined) begin
                           phase_in = PH_IDLE;  st_in = S_EMIT;
                        end else begin
                           if (side_ff == SIDE_LOWER) begin
                              fb_in = v_cl;  good_in = a_ff;
                           end else begin
                              fa_in = v_cl;  good_in = b_ff;
                           end
                           iter_in = '0;  phase_in = PH_BISECT_W;  st_in = S_BIS_AVG;
                        end
                     end
                     PH_BRENT: begin
                        if (req_value_undefined) begin
                           pend_err_in = ERR_UNDEF_ITER;  phase_in = PH_IDLE;  st_in = S_EMIT;
                        end else begin
                           fb_in = v_cl;  iter_in = iter_ff + 1'b1;
                           if (iter_ff + 1'b1 >= maxit_ff) begin
                              pend_err_in = ERR_TOO_MANY;  phase_in = PH_IDLE;  st_in = S_EMIT;
                           end else begin
                              st_in = S_B0;
                           end
                        end
                     end
                     default: st_in = S_IDLE;
                  endcase
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;  rsp_kind_in = pend_kind_ff;
               rsp_point_in = 64'(pend_pt_ff);  rsp_err_in = pend_err_ff;
               st_in = S_IDLE;
            end
         end
         S_BIS_AVG: begin
            use_alu = 1'b1;  alu_op_c = OP_AVG;  alu_x_c = bad_ff;  alu_y_c = good_ff;
            if (alu_done) begin
               c_in = alu_res;  pend_kind_in = KIND_REQUEST;  pend_pt_in = alu_res;
               pend_err_in = ERR_NONE;  st_in = S_EMIT;
            end
         end
         S_WID_A: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = a_ff;  alu_y_c = st_q;
            if (alu_done) begin
               a_in = alu_res;  pend_kind_in = KIND_REQUEST;  pend_pt_in = alu_res;
               pend_err_in = ERR_NONE;  st_in = S_EMIT;
            end
         end
         S_WID_B: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = b_ff;  alu_y_c = st_q;
            if (alu_done) begin
               b_in = alu_res;  pend_kind_in = KIND_REQUEST;  pend_pt_in = alu_res;
               pend_err_in = ERR_NONE;  st_in = S_EMIT;
            end
         end
         S_NEXT_BR: begin
            pend_kind_in = KIND_FAIL;  pend_pt_in = '0;
            if ((fa_ff < 0 && fb_ff > 0) || (fa_ff > 0 && fb_ff < 0)) begin
               fc_in = fb_ff;  iter_in = '0;
               if (maxit_ff == '0) begin
                  pend_err_in = ERR_TOO_MANY;  phase_in = PH_IDLE;  st_in = S_EMIT;
               end else begin
                  st_in = S_B0;
               end
            end else if (tries_ff >= maxtry_ff) begin
               pend_err_in = ERR_NOT_BRACKETED;  phase_in = PH_IDLE;  st_in = S_EMIT;
            end else if (side_ff == SIDE_NONE) begin
               phase_in = PH_WIDEN_A;  st_in = S_WID_A;
            end else if (side_ff == SIDE_LOWER) begin
               phase_in = PH_WIDEN_ONE;  st_in = S_WID_B;
            end else begin
               phase_in = PH_WIDEN_ONE;  st_in = S_WID_A;
            end
         end
         S_B0: begin
            // same sign at b and c: restart the bracket from a
            if ((fb_ff > 0 && fc_ff > 0) || (fb_ff < 0 && fc_ff < 0)) begin
               c_in = a_ff;  fc_in = fa_ff;  st_in = S_B0S;
            end else begin
               st_in = S_B1;
            end
         end
         S_B0S: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = b_ff;  alu_y_c = a_ff;
            if (alu_done) begin
               d_in = alu_res;  e_in = alu_res;  st_in = S_B1;
            end
         end
         S_B1: begin
            if (abs_q(fc_ff) < abs_q(fb_ff)) begin
               a_in = b_ff;  b_in = c_ff;  c_in = b_ff;
               fa_in = fb_ff;  fb_in = fc_ff;  fc_in = fb_ff;
            end
            st_in = S_B2;
         end
         S_B2: begin
            use_alu = 1'b1;  alu_op_c = OP_MULE;  alu_x_c = eps_q;  alu_y_c = abs_q(b_ff);
            if (alu_done) begin t1_in = alu_res;  st_in = S_B3; end
         end
         S_B3: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = t1_ff;  alu_y_c = t1_ff;
            if (alu_done) begin tol_in = alu_res;  st_in = S_B4; end
         end
         S_B4: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = tol_ff;  alu_y_c = atol_q;
            if (alu_done) begin tol_in = alu_res;  st_in = S_B5; end
         end
         S_B5: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = c_ff;  alu_y_c = b_ff;
            if (alu_done) begin t2_in = alu_res;  st_in = S_B6; end
         end
         S_B6: begin
            use_alu = 1'b1;  alu_op_c = OP_HALF;  alu_x_c = t2_ff;
            if (alu_done) begin m_in = alu_res;  st_in = S_B7; end
         end
         S_B7: begin
            if (abs_q(m_ff) <= tol_ff || fb_ff == '0) begin
               pend_kind_in = KIND_ROOT;  pend_pt_in = b_ff;  pend_err_in = ERR_NONE;
               phase_in = PH_IDLE;  st_in = S_EMIT;
            end else if (abs_q(e_ff) < tol_ff || abs_q(fa_ff) <= abs_q(fb_ff)) begin
               d_in = m_ff;  e_in = m_ff;  st_in = S_STEP;
            end else begin
               st_in = S_B8;
            end
         end
         S_B8: begin
            use_alu = 1'b1;  alu_op_c = OP_DIV;  alu_x_c = fb_ff;  alu_y_c = fa_ff;
            if (alu_done) begin s_in = alu_res;  st_in = S_B9; end
         end
         S_B9: st_in = (a_ff == c_ff) ? S_S1 : S_I1;
         // secant step
         S_S1: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = m_ff;  alu_y_c = m_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_S2; end
         end
         S_S2: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = t1_ff;  alu_y_c = s_ff;
            if (alu_done) begin p_in = alu_res;  st_in = S_S3; end
         end
         S_S3: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = ONE_Q;  alu_y_c = s_ff;
            if (alu_done) begin q_in = alu_res;  st_in = S_SIGN; end
         end
         // inverse quadratic interpolation
         S_I1: begin
            use_alu = 1'b1;  alu_op_c = OP_DIV;  alu_x_c = fa_ff;  alu_y_c = fc_ff;
            if (alu_done) begin q_in = alu_res;  st_in = S_I2; end
         end
         S_I2: begin
            use_alu = 1'b1;  alu_op_c = OP_DIV;  alu_x_c = fb_ff;  alu_y_c = fc_ff;
            if (alu_done) begin r_in = alu_res;  st_in = S_I3; end
         end
         S_I3: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = m_ff;  alu_y_c = m_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_I4; end
         end
         S_I4: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = t1_ff;  alu_y_c = q_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_I5; end
         end
         S_I5: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = q_ff;  alu_y_c = r_ff;
            if (alu_done) begin t2_in = alu_res;  st_in = S_I6; end
         end
         S_I6: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = t1_ff;  alu_y_c = t2_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_I7; end
         end
         S_I7: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = b_ff;  alu_y_c = a_ff;
            if (alu_done) begin t2_in = alu_res;  st_in = S_I8; end
         end
         S_I8: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = r_ff;  alu_y_c = ONE_Q;
            if (alu_done) begin p_in = alu_res;  st_in = S_I9; end
         end
         S_I9: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = t2_ff;  alu_y_c = p_ff;
            if (alu_done) begin t2_in = alu_res;  st_in = S_I10; end
         end
         S_I10: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = t1_ff;  alu_y_c = t2_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_I11; end
         end
         S_I11: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = s_ff;  alu_y_c = t1_ff;
            if (alu_done) begin p_in = alu_res;  st_in = S_I12; end
         end
         S_I12: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = q_ff;  alu_y_c = ONE_Q;
            if (alu_done) begin t1_in = alu_res;  st_in = S_I13; end
         end
         S_I13: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = r_ff;  alu_y_c = ONE_Q;
            if (alu_done) begin t2_in = alu_res;  st_in = S_I14; end
         end
         S_I14: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = t1_ff;  alu_y_c = t2_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_I15; end
         end
         S_I15: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = s_ff;  alu_y_c = ONE_Q;
            if (alu_done) begin t2_in = alu_res;  st_in = S_I16; end
         end
         S_I16: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = t1_ff;  alu_y_c = t2_ff;
            if (alu_done) begin q_in = alu_res;  st_in = S_SIGN; end
         end
         S_SIGN: begin
            if (p_ff > 0) q_in = neg_q(q_ff);
            else p_in = neg_q(p_ff);
            s_in = e_ff;  e_in = d_ff;
            st_in = S_C1;
         end
         // acceptance test for the interpolated step
         S_C1: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = m_ff;  alu_y_c = m_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_C2; end
         end
         S_C2: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = t1_ff;  alu_y_c = m_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_C3; end
         end
         S_C3: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = t1_ff;  alu_y_c = q_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_C4; end
         end
         S_C4: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = tol_ff;  alu_y_c = q_ff;
            if (alu_done) begin t2_in = alu_res;  st_in = S_C5; end
         end
         S_C5: begin
            use_alu = 1'b1;  alu_op_c = OP_SUB;  alu_x_c = t1_ff;  alu_y_c = abs_q(t2_ff);
            if (alu_done) begin t1_in = alu_res;  st_in = S_C6; end
         end
         S_C6: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = p_ff;  alu_y_c = p_ff;
            if (alu_done) begin t2_in = alu_res;  st_in = S_C7; end
         end
         S_C7: begin
            if (t2_ff < t1_ff) begin
               st_in = S_C8;
            end else begin
               d_in = m_ff;  e_in = m_ff;  st_in = S_STEP;
            end
         end
         S_C8: begin
            use_alu = 1'b1;  alu_op_c = OP_MUL;  alu_x_c = s_ff;  alu_y_c = q_ff;
            if (alu_done) begin t1_in = alu_res;  st_in = S_C9; end
         end
         S_C9: begin
            use_alu = 1'b1;  alu_op_c = OP_HALF;  alu_x_c = abs_q(t1_ff);
            if (alu_done) begin t1_in = alu_res;  st_in = S_C10; end
         end
         S_C10: begin
            if (p_ff < t1_ff) begin
               st_in = S_C11;
            end else begin
               d_in = m_ff;  e_in = m_ff;  st_in = S_STEP;
            end
         end
         S_C11: begin
            use_alu = 1'b1;  alu_op_c = OP_DIV;  alu_x_c = p_ff;  alu_y_c = q_ff;
            if (alu_done) begin d_in = alu_res;  st_in = S_STEP; end
         end
         S_STEP: begin
            use_alu = 1'b1;  alu_op_c = OP_ADD;  alu_x_c = b_ff;  alu_y_c = step_c;
            if (!wait_ff) begin
               a_in = b_ff;  fa_in = fb_ff;
            end
            if (alu_done) begin
               b_in = alu_res;  pend_kind_in = KIND_REQUEST;  pend_pt_in = alu_res;
               pend_err_in = ERR_NONE;  phase_in = PH_BRENT;  st_in = S_EMIT;
            end
         end
         default: st_in = S_IDLE;
      endcase

      wait_in = use_alu && !(wait_ff && alu_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widen_ff  <= RST_WIDEN_STEP;
         atol_ff   <= RST_ABS_TOL;
         eps_ff    <= RST_REL_EPS;
         maxtry_ff <= RST_MAX_TRIES;
         maxit_ff  <= RST_MAX_ITER;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIDEN_STEP: widen_ff  <= csr_data;
            CSR_ABS_TOL:    atol_ff   <= csr_data;
            CSR_REL_EPS:    eps_ff    <= csr_data[39:0];
            CSR_MAX_TRIES:  maxtry_ff <= csr_data[3:0];
            CSR_MAX_ITER:   maxit_ff  <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;  phase_ff <= PH_IDLE;  wait_ff <= 1'b0;
         side_ff <= SIDE_NONE;  iter_ff <= '0;  tries_ff <= '0;
         b_ff <= '0;  a_ff <= '0;  c_ff <= '0;  d_ff <= '0;  e_ff <= '0;
         fb_ff <= '0;  fa_ff <= '0;  fc_ff <= '0;  bad_ff <= '0;  good_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  phase_ff <= phase_in;  wait_ff <= wait_in;
         side_ff <= side_in;  iter_ff <= iter_in;  tries_ff <= tries_in;
         b_ff <= b_in;  a_ff <= a_in;  c_ff <= c_in;  d_ff <= d_in;  e_ff <= e_in;
         fb_ff <= fb_in;  fa_ff <= fa_in;  fc_ff <= fc_in;  bad_ff <= bad_in;  good_ff <= good_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tol_ff <= tol_in;  m_ff <= m_in;  s_ff <= s_in;  p_ff <= p_in;
      q_ff <= q_in;  r_ff <= r_in;  t1_ff <= t1_in;  t2_ff <= t2_in;
      pend_kind_ff <= pend_kind_in;  pend_pt_ff <= pend_pt_in;  pend_err_ff <= pend_err_in;
      rsp_kind_ff <= rsp_kind_in;  rsp_point_ff <= rsp_point_in;  rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_point       = rsp_point_ff;
   assign rsp_error_code  = rsp_err_ff;

endmodule
`default_nettype wire
